// ===== src/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Invariant checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

// ===== src/ffa_pkg.sv =====
// Package for the first-fit aligned allocator: types, codes, constants.
// No dependencies.
`default_nettype none
package ffa_pkg;
	localparam int unsigned ARENA_BYTES_DEF  = 1024 * 1024;
	localparam int unsigned MAX_BLOCKS_DEF   = 256;
	localparam int unsigned HEADER_BYTES_DEF = 24;
	localparam int unsigned HEADER_ALIGN_DEF = 8;

	localparam int unsigned OFS_W   = 21;
	localparam int unsigned ALIGN_W = 13;
	// Internal offsets keep headroom above the arena so sums never wrap.
	localparam int unsigned EXT_W   = 24;
	localparam int unsigned ENTRY_W = 3 * OFS_W;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [0:0]         op;
		logic [ALIGN_W-1:0] align_bytes;
		logic [OFS_W-1:0]   request_bytes;
		logic [OFS_W-1:0]   release_offset;
	} req_t;

	typedef struct packed {
		logic [OFS_W-1:0] data_offset;
		logic [1:0]       status;
	} rsp_t;

	typedef struct packed {
		logic [OFS_W-1:0] header;
		logic [OFS_W-1:0] data;
		logic [OFS_W-1:0] size;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,      // read issued for entry idx
		S_CHK,     // entry data valid; evaluate gap / match
		S_DIV,     // round data start up to align (serial divide)
		S_FIT,     // compare limit with data start
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== src/ffa_ram.sv =====
// Generic RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module ffa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/ffa_rounder.sv =====
// Serial round-up unit: y = ceil(x / a) * a, one quotient bit per cycle.
// Depends on ffa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ffa_rounder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [ffa_pkg::EXT_W-1:0]          x,
	input  wire logic [ffa_pkg::ALIGN_W-1:0]        a,
	output logic                                    busy,
	output logic                                    done,
	output logic      [ffa_pkg::EXT_W-1:0]          y
);
	localparam int unsigned W  = ffa_pkg::EXT_W;
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]        num_q;   // shifts out dividend bits
	logic [W-1:0]        rem_q;
	logic [W-1:0]        x_q;
	logic [W-1:0]        div_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [W:0]          trial;
	logic [W-1:0]        rem_n;

	// Restoring division step.
	always_comb begin
		trial = {rem_q, num_q[W-1]} - {1'b0, div_q};
		rem_n = trial[W] ? {rem_q[W-2:0], num_q[W-1]} : trial[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= x;
			x_q   <= x;
			rem_q <= '0;
			div_q <= (a == '0) ? W'(1) : W'(a);
		end else if (busy_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			rem_q <= rem_n;
		end
	end

	// x + (a - rem) when rem is nonzero.
	assign y    = (rem_q == '0) ? x_q : x_q + (div_q - rem_q);
	assign busy = busy_q;
	assign done = done_q;

	`ASSERT_IMPL(a_rnd_no_restart, clk, arst_n, busy_q, !start, "rounder restarted while busy")
	`ASSERT_IMPL(a_rnd_done_idle, clk, arst_n, done_q, !busy_q, "done while busy")
	`ASSERT_IMPL(a_rnd_divisor, clk, arst_n, busy_q, div_q != '0, "zero divisor")
endmodule
`default_nettype wire

// ===== src/first_fit_aligned_allocator_unit.sv =====
// Top level of the first-fit aligned allocator: control sequencer over the block table.
// Depends on ffa_pkg, ffa_ram, ffa_rounder and assert_macros.svh.
// One request at a time: a result must be taken before the next request is accepted.
// An allocate examines one gap at a time (read, check, serial round-up to the requested
// alignment, compare), then moves entries up one at a time to open a slot, writes the
// new entry and posts the result. The worst case, MAX_BLOCKS - 1 live entries and no
// fit, examines MAX_BLOCKS gaps. A free compares one entry at a time (walking to the end
// when nothing matches), then moves the entries after the match down and posts the
// result. With a full table an allocate goes from the read state straight to posting.
// The table sits in one RAM of MAX_BLOCKS entries with one write and one registered read
// port; the registered read is why each moved entry takes a read state and a write state.
// Header rounding to HEADER_ALIGN is a constant reciprocal multiply registered during
// the read cycle.
// No clearing pass is needed after reset: only entries below the live count are used.
`default_nettype none
`include "assert_macros.svh"
module first_fit_aligned_allocator_unit #(
	parameter int unsigned ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
	parameter int unsigned MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
	parameter int unsigned HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int unsigned HEADER_ALIGN = ffa_pkg::HEADER_ALIGN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ffa_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ffa_pkg::rsp_t      out_data
);
	localparam int unsigned W  = ffa_pkg::EXT_W;
	localparam int unsigned AW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned OW = ffa_pkg::OFS_W;
	// Reciprocal for the header rounding: exact floor(n / HEADER_ALIGN) for n < 2^NW
	localparam int unsigned NW = W + 1;
	localparam int unsigned HL = $clog2(HEADER_ALIGN);
	localparam int unsigned PW = 2 * NW + 1;
	localparam longint unsigned HMUL =
		((64'd1 << (NW + HL)) + 64'(HEADER_ALIGN) - 64'd1) / 64'(HEADER_ALIGN);

	ffa_pkg::state_t state_q, state_n;
	ffa_pkg::req_t   req_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;      // current walk position
	logic [CW-1:0]   mv_q;       // shift pointer
	logic [W-1:0]    prev_end_q;
	logic [W-1:0]    hdr_q;
	logic [W-1:0]    dat_q;
	logic [W-1:0]    lim_q;
	ffa_pkg::rsp_t   rsp_q;
	logic            out_valid_q;

	// RAM port
	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	ffa_pkg::entry_t ram_wdata, ram_rdata;

	ffa_ram #(.WIDTH(ffa_pkg::ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// Round-up unit for the requested alignment
	logic         rnd_start, rnd_busy, rnd_done;
	logic [W-1:0] rnd_x, rnd_y;
	ffa_rounder u_rnd (
		.clk(clk), .arst_n(arst_n), .start(rnd_start), .x(rnd_x),
		.a(req_q.align_bytes), .busy(rnd_busy), .done(rnd_done), .y(rnd_y)
	);

	// Header placement: round to HEADER_ALIGN by reciprocal multiply.
	// prev_end_q settles on entry to S_RD, so the quotient is ready in S_CHK.
	logic [NW-1:0] hnum;
	logic [PW-1:0] hprod;
	logic [W-1:0]  hquo_q;
	logic [W-1:0]  hdr_c;
	assign hnum  = NW'(prev_end_q) + NW'(HEADER_ALIGN - 1);
	assign hprod = PW'(hnum) * PW'(HMUL);

	always_ff @(posedge clk) begin
		hquo_q <= W'(hprod >> (NW + HL));
	end

	assign hdr_c = hquo_q * W'(HEADER_ALIGN);
	assign rnd_x = hdr_c + W'(HEADER_BYTES);

	logic last_gap;
	assign last_gap = (idx_q == count_q);
	logic is_free;
	assign is_free = (req_q.op == ffa_pkg::OP_FREE);

	// State register and payload registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffa_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ffa_pkg::S_DONE) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == ffa_pkg::S_SHIFT_WR) begin
				if (is_free && (mv_q + 1'b1 >= count_q)) begin
					count_q <= count_q - 1'b1;
				end else if (!is_free && mv_q == idx_q) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ffa_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					req_q      <= in_data;
					idx_q      <= '0;
					prev_end_q <= W'(HEADER_BYTES);
					rsp_q      <= '0;
				end
			end
			ffa_pkg::S_CHK: begin
				if (is_free) begin
					if (!last_gap && W'(ram_rdata.data) == W'(req_q.release_offset)) begin
						mv_q <= idx_q;
					end else if (!last_gap) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						rsp_q.status <= ffa_pkg::ST_NOTFOUND;
					end
				end else begin
					hdr_q <= hdr_c;
					lim_q <= last_gap ? W'(ARENA_BYTES) : W'(ram_rdata.header);
				end
			end
			ffa_pkg::S_DIV: begin
				if (rnd_done) begin
					dat_q <= rnd_y;
				end
			end
			ffa_pkg::S_FIT: begin
				if (lim_q > dat_q && (lim_q - dat_q) >= W'(req_q.request_bytes)) begin
					mv_q <= count_q;
					rsp_q.data_offset <= OW'(dat_q);
				end else if (last_gap) begin
					rsp_q.status <= ffa_pkg::ST_NOFIT;
				end else begin
					prev_end_q <= W'(ram_rdata.data) + W'(ram_rdata.size);
					idx_q      <= idx_q + 1'b1;
				end
			end
			ffa_pkg::S_SHIFT_WR: begin
				// Free walks up to the end; alloc walks down to the insert slot.
				if (is_free) begin
					mv_q <= mv_q + 1'b1;
				end else if (mv_q != idx_q) begin
					mv_q <= mv_q - 1'b1;
				end
			end
			default: begin
				if (state_q == ffa_pkg::S_RD && !is_free && count_q == CW'(MAX_BLOCKS)) begin
					rsp_q.status <= ffa_pkg::ST_FULL;
				end
			end
		endcase
	end

	// Next state and RAM control
	always_comb begin
		state_n   = state_q;
		ram_we    = 1'b0;
		ram_waddr = mv_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		rnd_start = 1'b0;
		unique case (state_q)
			ffa_pkg::S_IDLE: begin
				if (in_valid && !out_valid_q) begin
					state_n = ffa_pkg::S_RD;
				end
			end
			ffa_pkg::S_RD: begin
				if (!is_free && count_q == CW'(MAX_BLOCKS)) begin
					state_n = ffa_pkg::S_DONE;
				end else begin
					state_n = ffa_pkg::S_CHK;
				end
			end
			ffa_pkg::S_CHK: begin
				if (is_free) begin
					if (!last_gap && W'(ram_rdata.data) == W'(req_q.release_offset)) begin
						state_n = ffa_pkg::S_SHIFT_RD;
					end else if (!last_gap) begin
						state_n = ffa_pkg::S_RD;
					end else begin
						state_n = ffa_pkg::S_DONE;
					end
				end else begin
					rnd_start = 1'b1;
					state_n   = ffa_pkg::S_DIV;
				end
			end
			ffa_pkg::S_DIV: begin
				if (rnd_done) begin
					state_n = ffa_pkg::S_FIT;
				end
			end
			ffa_pkg::S_FIT: begin
				if (lim_q > dat_q && (lim_q - dat_q) >= W'(req_q.request_bytes)) begin
					state_n = ffa_pkg::S_SHIFT_RD;
				end else if (last_gap) begin
					state_n = ffa_pkg::S_DONE;
				end else begin
					state_n   = ffa_pkg::S_RD;
					ram_raddr = AW'(idx_q + 1'b1);
				end
			end
			ffa_pkg::S_SHIFT_RD: begin
				// Free pulls entry mv+1 down; alloc pushes entry mv-1 up.
				ram_raddr = is_free ? AW'(mv_q + 1'b1) : AW'(mv_q - 1'b1);
				state_n   = ffa_pkg::S_SHIFT_WR;
			end
			ffa_pkg::S_SHIFT_WR: begin
				ram_we = 1'b1;
				if (is_free) begin
					if (mv_q + 1'b1 >= count_q) begin
						ram_we  = 1'b0;
						state_n = ffa_pkg::S_DONE;
					end else begin
						state_n = ffa_pkg::S_SHIFT_RD;
					end
				end else if (mv_q == idx_q) begin
					ram_wdata = '{header: OW'(hdr_q), data: OW'(dat_q),
						size: req_q.request_bytes};
					state_n   = ffa_pkg::S_DONE;
				end else begin
					state_n = ffa_pkg::S_SHIFT_RD;
				end
			end
			ffa_pkg::S_DONE: begin
				state_n = ffa_pkg::S_IDLE;
			end
			default: begin
				state_n = ffa_pkg::S_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == ffa_pkg::S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	`ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CW'(MAX_BLOCKS), "count over depth")
	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != ffa_pkg::S_IDLE, !in_ready, "busy")
	`ASSERT_IMPL(a_write_in_shift, clk, arst_n, ram_we, state_q == ffa_pkg::S_SHIFT_WR, "write")
	`ASSERT_IMPL(a_rnd_in_div, clk, arst_n, rnd_busy, state_q == ffa_pkg::S_DIV, "divider")
endmodule
`default_nettype wire

// ===== bench/tb_first_fit_aligned_allocator_unit.sv =====
// Testbench for the first-fit aligned allocator: random and directed allocate/free traffic,
// results checked against an in-bench table model. Depends on ffa_pkg and the top level.
`default_nettype none
module tb_first_fit_aligned_allocator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ARENA    = ffa_pkg::ARENA_BYTES_DEF;
	localparam int unsigned SLOTS    = ffa_pkg::MAX_BLOCKS_DEF;
	localparam int unsigned HDR      = ffa_pkg::HEADER_BYTES_DEF;
	localparam int unsigned HDR_ALN  = ffa_pkg::HEADER_ALIGN_DEF;
	localparam int unsigned OW       = ffa_pkg::OFS_W;
	localparam int unsigned AL       = ffa_pkg::ALIGN_W;
	localparam int unsigned STALL_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ffa_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ffa_pkg::rsp_t out_data;

	always #5 clk = ~clk;

	first_fit_aligned_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// live-block table mirror, address ordered
	longint unsigned blk_hdr[$];
	longint unsigned blk_dat[$];
	longint unsigned blk_size[$];

	ffa_pkg::req_t pending_reqs[$];
	ffa_pkg::rsp_t expected_rsps[$];
	int errors = 0;
	bit stim_done = 0;
	bit calm = 0;   // stretch with no idling

	function automatic longint unsigned round_to(longint unsigned x, longint unsigned a);
		if (a == 0) a = 1;
		return ((x + a - 1) / a) * a;
	endfunction

	// compute the response for one request and update the mirror
	function automatic ffa_pkg::rsp_t alloc_predict(ffa_pkg::req_t r);
		ffa_pkg::rsp_t res;
		longint unsigned prev_end, h, d, lim;
		int n;
		res = '0;
		n = blk_dat.size();
		if (ffa_pkg::op_t'(r.op) == ffa_pkg::OP_ALLOC) begin
			if (n >= SLOTS) begin
				res.status = ffa_pkg::ST_FULL;
				return res;
			end
			prev_end = HDR;
			for (int i = 0; i <= n; i++) begin
				h = round_to(prev_end, HDR_ALN);
				d = round_to(h + HDR, r.align_bytes);
				lim = (i < n) ? blk_hdr[i] : ARENA;
				if (lim > d && lim - d >= r.request_bytes) begin
					blk_hdr.insert(i, h);
					blk_dat.insert(i, d);
					blk_size.insert(i, r.request_bytes);
					res.data_offset = d[OW-1:0];
					res.status = ffa_pkg::ST_OK;
					return res;
				end
				if (i < n) prev_end = blk_dat[i] + blk_size[i];
			end
			res.status = ffa_pkg::ST_NOFIT;
		end else begin
			for (int i = 0; i < n; i++) begin
				if (blk_dat[i] == r.release_offset) begin
					blk_hdr.delete(i);
					blk_dat.delete(i);
					blk_size.delete(i);
					res.status = ffa_pkg::ST_OK;
					return res;
				end
			end
			res.status = ffa_pkg::ST_NOTFOUND;
		end
		return res;
	endfunction

	function automatic ffa_pkg::req_t make_alloc(int unsigned aln, int unsigned sz);
		ffa_pkg::req_t r;
		r = '0;
		r.op = ffa_pkg::OP_ALLOC;
		r.align_bytes = aln[AL-1:0];
		r.request_bytes = sz[OW-1:0];
		r.release_offset = OW'($urandom);
		return r;
	endfunction

	function automatic ffa_pkg::req_t make_free(int unsigned ofs);
		ffa_pkg::req_t r;
		r = '0;
		r.op = ffa_pkg::OP_FREE;
		r.align_bytes = AL'($urandom);
		r.request_bytes = OW'($urandom);
		r.release_offset = ofs[OW-1:0];
		return r;
	endfunction

	function automatic int unsigned rand_size();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 70) return $urandom_range(0, 2000);
		if (k < 90) return $urandom_range(0, 40000);
		if (k < 97) return $urandom_range(0, 1 << 20);
		return $urandom_range(0, (1 << 21) - 1);
	endfunction

	function automatic int unsigned rand_align();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 40) return 1 << $urandom_range(0, 12);
		if (k < 95) return $urandom_range(1, 4096);
		return $urandom_range(0, 8191);
	endfunction

	// stimulus
	initial begin
		int unsigned ofs;
		// directed: extremes, zero size, alignment corners, unknown frees
		pending_reqs.push_back(make_free(HDR));
		pending_reqs.push_back(make_free(0));
		pending_reqs.push_back(make_alloc(1, 0));
		pending_reqs.push_back(make_alloc(0, 16));
		pending_reqs.push_back(make_alloc(4096, 100));
		pending_reqs.push_back(make_alloc(4095, 3));
		pending_reqs.push_back(make_alloc(8191, 5));
		pending_reqs.push_back(make_alloc(1, (1 << 21) - 1));
		pending_reqs.push_back(make_alloc(1, 1 << 20));
		pending_reqs.push_back(make_free(HDR + HDR));
		pending_reqs.push_back(make_free((1 << 21) - 1));
		pending_reqs.push_back(make_alloc(7, 900000));
		pending_reqs.push_back(make_alloc(1, 200000));
		pending_reqs.push_back(make_alloc(3, 0));
		pending_reqs.push_back(make_alloc(4096, 4096));
		// random phase: mostly allocs and frees of real offsets
		repeat (807) begin
			if ($urandom_range(0, 99) < 55) begin
				if ($urandom_range(0, 9) < 3)
					pending_reqs.push_back(make_alloc(rand_align(), $urandom_range(0, 64)));
				else
					pending_reqs.push_back(make_alloc(rand_align(), rand_size()));
			end else if ($urandom_range(0, 99) < 80) begin
				// frees of plausible offsets: header aligned data starts
				ofs = $urandom_range(0, 400) * 8 + HDR + HDR;
				if ($urandom_range(0, 1)) ofs = $urandom_range(0, 4096) * 4096;
				pending_reqs.push_back(make_free(ofs));
			end else begin
				pending_reqs.push_back(make_free($urandom_range(0, (1 << 21) - 1)));
			end
		end
		// fill the table to the full condition with tiny blocks, then drain some
		repeat (SLOTS + 8) pending_reqs.push_back(make_alloc(1, $urandom_range(0, 8)));
		for (int i = 0; i < 64; i++) pending_reqs.push_back(make_free(2 * HDR + 32 * i));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// random frees above mostly miss; retarget some onto live blocks at drive time
	function automatic ffa_pkg::req_t retarget(ffa_pkg::req_t r);
		if (ffa_pkg::op_t'(r.op) == ffa_pkg::OP_FREE && blk_dat.size() > 0 &&
				$urandom_range(0, 99) < 70)
			r.release_offset = OW'(blk_dat[$urandom_range(0, blk_dat.size() - 1)]);
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_rsps.push_back(alloc_predict(in_data));
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
					in_data <= retarget(pending_reqs.pop_front());
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					if (pending_reqs.size() == 0) stim_done <= 1'b1;
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 19);
		end
	end

	// quiet stretch in the middle of the run
	initial begin
		#300000;
		calm = 1;
		#150000;
		calm = 0;
	end

	// monitor
	always @(posedge clk) begin
		ffa_pkg::rsp_t exp_rsp;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result data_offset=%0d status=%0d",
					out_data.data_offset, out_data.status);
				errors++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (out_data.data_offset !== exp_rsp.data_offset) begin
					$error("data_offset expected %0d actual %0d",
						exp_rsp.data_offset, out_data.data_offset);
					errors++;
				end
				if (out_data.status !== exp_rsp.status) begin
					$error("status expected %0d actual %0d",
						exp_rsp.status, out_data.status);
					errors++;
				end
			end
		end
	end

	// watchdog and end of run
	int idle_cycles = 0;
	initial begin
		int drain;
		drain = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
			if (stim_done && !in_valid && expected_rsps.size() == 0) begin
				drain++;
				if (drain > 50) break;
			end else
				drain = 0;
		end
		if (errors == 0 && expected_rsps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/ffa_pkg.sv
src/ffa_ram.sv
src/ffa_rounder.sv
src/first_fit_aligned_allocator_unit.sv
bench/tb_first_fit_aligned_allocator_unit.sv
